/* hdl/lzwc_pkg.sv */
// lzwc_pkg: shared constants and command/status types for the lzw compressor
// no dependencies
package lzwc_pkg;
    localparam int MAX_CODE_BITS_DEF = 15;
    localparam int HASH_ENTRIES_DEF  = 35023;
    localparam logic [15:0] CODE_END   = 16'd256;
    localparam logic [15:0] CODE_BUMP  = 16'd257;
    localparam logic [15:0] CODE_FLUSH = 16'd258;
    localparam logic [15:0] CODE_FIRST = 16'd259;
    localparam logic [15:0] THRESH_RST = 16'd511;
    localparam logic [4:0]  WIDTH_RST  = 5'd9;

    localparam logic [2:0] EMIT_PREFIX = 3'd0;
    localparam logic [2:0] EMIT_END    = 3'd1;
    localparam logic [2:0] EMIT_FLUSH  = 3'd2;
    localparam logic [2:0] EMIT_BUMP   = 3'd3;

    typedef struct packed {
        logic       take_item;
        logic       clr_step;
        logic       hash_start;
        logic       probe_step;
        logic       ins_write;
        logic       match_take;
        logic       first_take;
        logic       load_code;
        logic [2:0] emit_sel;
        logic       shift_bit;
        logic       pad_load;
        logic       push_beat;
        logic       after_ins;
        logic       do_flush;
        logic       do_bump;
        logic       finish_reset;
    } lzwc_cmd_t;

    typedef struct packed {
        logic mode;
        logic prefix_valid;
        logic clr_done;
        logic slot_free;
        logic slot_match;
        logic probe_exhaust;
        logic bits_left;
        logic bits_few;
        logic acc_full;
        logic acc_partial;
        logic code_limit;
        logic code_thresh;
    } lzwc_stat_t;
endpackage

/* hdl/lzw_variable_width_compressor_core.sv */
// lzw compressor top level: controller plus datapath
// a data beat passes idle, dispatch and then one probe state visit per hash probe; a match goes back to idle
// each emitted code is loaded, then shifted out bit by bit (one-bit packer), with a beat state per finished byte
// bit packing stalls while a held output beat waits; a beat is offered after its 8th bit
// synchronous reset, then a clearing pass over all HASH_ENTRIES slots with s_ready low;
// the same pass follows every flush code and every finish beat
// depends on lzwc_pkg, lzwc_ctrl, lzwc_datapath
module lzw_variable_width_compressor_core #(
    parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF,
    parameter int HASH_ENTRIES  = lzwc_pkg::HASH_ENTRIES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run
);
    lzwc_pkg::lzwc_cmd_t  cmd;
    lzwc_pkg::lzwc_stat_t stat;

    lzwc_ctrl u_ctrl (
        .aclk, .aresetn, .stat, .cmd, .s_valid, .s_ready,
        .m_valid, .m_ready, .m_last_of_run
    );

    lzwc_datapath #(.MAX_CODE_BITS(MAX_CODE_BITS), .HASH_ENTRIES(HASH_ENTRIES)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .s_mode, .s_data_byte, .beat_data(m_out_byte)
    );
endmodule

/* hdl/lzwc_datapath.sv */
// lzwc_datapath: hash dictionary memories, prefix and width state, bit packer
// depends on lzwc_pkg
module lzwc_datapath #(
    parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF,
    parameter int HASH_ENTRIES  = lzwc_pkg::HASH_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lzwc_pkg::lzwc_cmd_t cmd,
    output lzwc_pkg::lzwc_stat_t stat,
    input  logic                s_mode,
    input  logic [7:0]          s_data_byte,
    output logic [7:0]          beat_data
);
    localparam int AW = $clog2(HASH_ENTRIES);
    localparam int CW = MAX_CODE_BITS;
    localparam logic [16:0] LIMIT = 17'((17'd1 << MAX_CODE_BITS) - 17'd1);
    localparam logic [AW-1:0] HE = AW'(HASH_ENTRIES);

    logic          v_mem [HASH_ENTRIES];
    logic [CW-1:0] c_mem [HASH_ENTRIES];
    logic [CW-1:0] p_mem [HASH_ENTRIES];
    logic [7:0]    ch_mem [HASH_ENTRIES];

    logic          mode_reg;
    logic [7:0]    ch_reg;
    logic [CW-1:0] prefix_reg;
    logic          pvalid_reg;
    logic [16:0]   nfc_reg;
    logic [4:0]    width_reg;
    logic [16:0]   thresh_reg;
    logic [7:0]    acc_reg;
    logic [2:0]    bpos_reg;
    logic [15:0]   code_reg;
    logic [4:0]    bits_reg;
    logic [AW-1:0] idx_reg, off_reg, clr_reg;
    logic [16:0]   probes_reg;
    logic          rd_v_reg;
    logic [CW-1:0] rd_c_reg, rd_p_reg;
    logic [7:0]    rd_ch_reg;

    logic [15:0]   hraw;
    logic [AW-1:0] hidx, hoff, idx_next;
    logic [15:0]   emit_code;

    always_comb begin
        hraw = 16'({8'd0, ch_reg} << (MAX_CODE_BITS - 8)) ^ 16'(prefix_reg);
        if (17'(hraw) >= 17'(HASH_ENTRIES)) hidx = AW'(17'(hraw) - 17'(HASH_ENTRIES));
        else hidx = AW'(hraw);
        hoff = (hidx == '0) ? AW'(1) : AW'(HE - hidx);
        if (idx_reg >= off_reg) idx_next = idx_reg - off_reg;
        else idx_next = AW'(17'(idx_reg) + 17'(HASH_ENTRIES) - 17'(off_reg));
        case (cmd.emit_sel)
            lzwc_pkg::EMIT_PREFIX: emit_code = 16'(prefix_reg);
            lzwc_pkg::EMIT_END:    emit_code = lzwc_pkg::CODE_END;
            lzwc_pkg::EMIT_FLUSH:  emit_code = lzwc_pkg::CODE_FLUSH;
            default:               emit_code = lzwc_pkg::CODE_BUMP;
        endcase
    end

    // memories: one write port (clear or insert) and a registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) v_mem[clr_reg] <= 1'b0;
        else if (cmd.ins_write) begin
            v_mem[idx_reg]  <= 1'b1;
            c_mem[idx_reg]  <= CW'(nfc_reg);
            p_mem[idx_reg]  <= prefix_reg;
            ch_mem[idx_reg] <= ch_reg;
        end
        rd_v_reg  <= v_mem[cmd.hash_start ? hidx : idx_next];
        rd_c_reg  <= c_mem[cmd.hash_start ? hidx : idx_next];
        rd_p_reg  <= p_mem[cmd.hash_start ? hidx : idx_next];
        rd_ch_reg <= ch_mem[cmd.hash_start ? hidx : idx_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish_reset) begin
            pvalid_reg <= 1'b0;
            prefix_reg <= '0;
            nfc_reg    <= 17'(lzwc_pkg::CODE_FIRST);
            width_reg  <= lzwc_pkg::WIDTH_RST;
            thresh_reg <= 17'(lzwc_pkg::THRESH_RST);
            acc_reg    <= '0;
            bpos_reg   <= '0;
            clr_reg    <= '0;
        end else begin
            if (cmd.take_item) begin
                mode_reg <= s_mode;
                ch_reg   <= s_data_byte;
            end
            if (cmd.clr_step) clr_reg <= clr_reg + AW'(1);
            if (cmd.do_flush) clr_reg <= '0;
            if (cmd.first_take) begin
                prefix_reg <= CW'(ch_reg);
                pvalid_reg <= 1'b1;
            end
            if (cmd.hash_start) begin
                idx_reg    <= hidx;
                off_reg    <= hoff;
                probes_reg <= 17'd1;
            end else if (cmd.probe_step) begin
                idx_reg    <= idx_next;
                probes_reg <= probes_reg + 17'd1;
            end
            if (cmd.match_take) prefix_reg <= rd_c_reg;
            if (cmd.after_ins) begin
                nfc_reg    <= nfc_reg + 17'd1;
                prefix_reg <= CW'(ch_reg);
            end
            if (cmd.do_flush) begin
                nfc_reg    <= 17'(lzwc_pkg::CODE_FIRST);
                width_reg  <= lzwc_pkg::WIDTH_RST;
                thresh_reg <= 17'(lzwc_pkg::THRESH_RST);
            end
            if (cmd.do_bump) begin
                width_reg  <= width_reg + 5'd1;
                thresh_reg <= {thresh_reg[15:0], 1'b1};
            end
            if (cmd.load_code) begin
                code_reg <= emit_code;
                bits_reg <= width_reg;
            end
            if (cmd.shift_bit) begin
                acc_reg[3'd7 - bpos_reg] <= code_reg[4'(bits_reg - 5'd1)];
                bpos_reg <= bpos_reg + 3'd1;
                bits_reg <= bits_reg - 5'd1;
            end
            if (cmd.push_beat) begin
                beat_data <= acc_reg;
                acc_reg   <= '0;
                if (cmd.pad_load) bpos_reg <= '0;
            end
        end
    end

    assign stat.mode          = mode_reg;
    assign stat.prefix_valid  = pvalid_reg;
    assign stat.clr_done      = (clr_reg == HE - AW'(1));
    assign stat.slot_free     = !rd_v_reg;
    assign stat.slot_match    = rd_v_reg && rd_p_reg == prefix_reg && rd_ch_reg == ch_reg;
    assign stat.probe_exhaust = (probes_reg >= 17'(HASH_ENTRIES));
    assign stat.bits_left     = (bits_reg != 5'd0);
    assign stat.bits_few      = (bits_reg < 5'd8);
    assign stat.acc_full      = (bpos_reg == 3'd7);
    assign stat.acc_partial   = (bpos_reg != 3'd0);
    assign stat.code_limit    = (nfc_reg > LIMIT);
    assign stat.code_thresh   = (nfc_reg > thresh_reg);
endmodule

/* hdl/lzwc_ctrl.sv */
// lzwc_ctrl: sequencer for clearing, hash probing, code emission and output beats
// depends on lzwc_pkg
module lzwc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lzwc_pkg::lzwc_stat_t stat,
    output lzwc_pkg::lzwc_cmd_t  cmd,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_last_of_run
);
    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DISP  = 4'd2;
    localparam logic [3:0] ST_PROBE = 4'd4;
    localparam logic [3:0] ST_LOAD  = 4'd5;
    localparam logic [3:0] ST_SHIFT = 4'd6;
    localparam logic [3:0] ST_BEAT  = 4'd7;
    localparam logic [3:0] ST_NEXT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic       ins_reg, ins_next;
    logic       mv_reg, mv_next, ml_reg, ml_next;
    logic       more_codes, beat_last;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        ins_next = ins_reg;
        mv_next = mv_reg && !m_ready;
        ml_next = ml_reg;
        s_ready = (state_reg == ST_IDLE);
        cmd.emit_sel = phase_reg;
        // another code of this item still follows the current one
        more_codes = ins_reg ? (phase_reg == lzwc_pkg::EMIT_PREFIX
                                && (stat.code_limit || stat.code_thresh))
                             : (phase_reg == lzwc_pkg::EMIT_PREFIX);
        beat_last = !more_codes && (ins_reg ? stat.bits_few : !stat.bits_left);
        case (state_reg)
            ST_CLR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: if (s_valid) begin
                cmd.take_item = 1'b1;
                state_next = ST_DISP;
            end
            ST_DISP: begin
                if (stat.mode) begin
                    phase_next = stat.prefix_valid ? lzwc_pkg::EMIT_PREFIX
                                                   : lzwc_pkg::EMIT_END;
                    ins_next = 1'b0;
                    state_next = ST_LOAD;
                end else if (!stat.prefix_valid) begin
                    cmd.first_take = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.hash_start = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (stat.slot_match) begin
                    cmd.match_take = 1'b1;
                    state_next = ST_IDLE;
                end else if (stat.slot_free || stat.probe_exhaust) begin
                    cmd.ins_write = stat.slot_free;
                    phase_next = lzwc_pkg::EMIT_PREFIX;
                    ins_next = 1'b1;
                    state_next = ST_LOAD;
                end else cmd.probe_step = 1'b1;
            end
            ST_LOAD: begin
                cmd.load_code = 1'b1;
                if (ins_reg && phase_reg == lzwc_pkg::EMIT_PREFIX) cmd.after_ins = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (!stat.bits_left) state_next = ST_NEXT;
                else if (!mv_reg || m_ready) begin
                    cmd.shift_bit = 1'b1;
                    if (stat.acc_full) state_next = ST_BEAT;
                end
            end
            ST_BEAT: begin
                cmd.push_beat = 1'b1;
                mv_next = 1'b1;
                ml_next = beat_last;
                state_next = stat.bits_left ? ST_SHIFT : ST_NEXT;
            end
            ST_NEXT: begin
                if (ins_reg && phase_reg == lzwc_pkg::EMIT_PREFIX && stat.code_limit) begin
                    phase_next = lzwc_pkg::EMIT_FLUSH;
                    state_next = ST_LOAD;
                end else if (ins_reg && phase_reg == lzwc_pkg::EMIT_PREFIX
                             && stat.code_thresh) begin
                    phase_next = lzwc_pkg::EMIT_BUMP;
                    state_next = ST_LOAD;
                end else if (!ins_reg && phase_reg == lzwc_pkg::EMIT_PREFIX) begin
                    phase_next = lzwc_pkg::EMIT_END;
                    state_next = ST_LOAD;
                end else if (!ins_reg && stat.acc_partial) begin
                    if (!mv_reg || m_ready) begin
                        cmd.push_beat = 1'b1;
                        cmd.pad_load = 1'b1;
                        mv_next = 1'b1;
                        ml_next = 1'b1;
                    end
                end else begin
                    if (phase_reg == lzwc_pkg::EMIT_FLUSH) begin
                        cmd.do_flush = 1'b1;
                        state_next = ST_CLR;
                    end else begin
                        cmd.do_bump = (phase_reg == lzwc_pkg::EMIT_BUMP);
                        state_next = ST_IDLE;
                    end
                    if (!ins_reg) begin
                        cmd.finish_reset = 1'b1;
                        state_next = ST_CLR;
                    end
                end
            end
            default: state_next = ST_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            phase_reg <= lzwc_pkg::EMIT_PREFIX;
            ins_reg <= 1'b0;
            mv_reg <= 1'b0;
            ml_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ins_reg <= ins_next;
            mv_reg <= mv_next;
            ml_reg <= ml_next;
        end
    end

    assign m_valid = mv_reg;
    assign m_last_of_run = ml_reg;

    ap_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    ap_beat_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_beat |-> (!mv_reg || m_ready || state_reg == ST_BEAT))
        else $error("beat overwrite");
    ap_clr_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLR |-> !s_ready) else $error("accept during clear");
endmodule

/* test/tb_lzw_variable_width_compressor_core.sv */
// testbench for lzw_variable_width_compressor_core: byte streams in, packed code beats checked
// against a behavioral lzw predictor kept in a small scoreboard class; depends on lzwc_pkg
module tb_lzw_variable_width_compressor_core;
    localparam int CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF;
    localparam int SLOTS     = lzwc_pkg::HASH_ENTRIES_DEF;
    localparam int CODE_MAX  = (1 << CODE_BITS) - 1;
    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
    } packed_beat_t;

    class lzw_scoreboard;
        bit          slot_used [SLOTS];
        logic [15:0] slot_code [SLOTS];
        logic [15:0] slot_parent [SLOTS];
        logic [7:0]  slot_char [SLOTS];
        int          prefix;
        bit          have_prefix;
        int          free_code;
        int          width;
        int          bump_at;
        logic [7:0]  acc;
        int          acc_bits;
        packed_beat_t beats_due[$];
        packed_beat_t beats_now[$];

        function new();
            restart();
        endfunction

        function void clear_dictionary();
            foreach (slot_used[i]) slot_used[i] = 0;
            free_code = lzwc_pkg::CODE_FIRST;
            width     = lzwc_pkg::WIDTH_RST;
            bump_at   = lzwc_pkg::THRESH_RST;
        endfunction

        function void restart();
            clear_dictionary();
            prefix      = 0;
            have_prefix = 0;
            acc         = '0;
            acc_bits    = 0;
        endfunction

        function void pack_code(int code, int w);
            packed_beat_t pb;
            for (int i = w - 1; i >= 0; i--) begin
                acc[7 - acc_bits] = code[i];
                acc_bits++;
                if (acc_bits == 8) begin
                    pb.out_byte = acc;
                    pb.last     = 1'b0;
                    beats_now.push_back(pb);
                    acc      = '0;
                    acc_bits = 0;
                end
            end
        endfunction

        // double-hash probe; returns 0 free, 1 match, 2 table full
        function int probe(int par, int ch, output int slot);
            int idx;
            int off;
            idx = ((ch << (CODE_BITS - 8)) ^ par) & 16'hFFFF;
            if (idx >= SLOTS) idx -= SLOTS;
            off = (idx == 0) ? 1 : SLOTS - idx;
            slot = 0;
            for (int n = 0; n < SLOTS; n++) begin
                if (!slot_used[idx]) begin
                    slot = idx;
                    return 0;
                end
                if (slot_parent[idx] == par && slot_char[idx] == ch) begin
                    slot = idx;
                    return 1;
                end
                if (idx >= off) idx -= off;
                else idx += SLOTS - off;
            end
            return 2;
        endfunction

        function void note_input(logic mode, logic [7:0] ch);
            packed_beat_t pb;
            int slot;
            int status;
            beats_now.delete();
            if (mode == MODE_FINISH) begin
                if (have_prefix) pack_code(prefix, width);
                pack_code(lzwc_pkg::CODE_END, width);
                if (acc_bits != 0) begin
                    pb.out_byte = acc;
                    pb.last     = 1'b0;
                    beats_now.push_back(pb);
                end
                restart();
            end else if (!have_prefix) begin
                prefix      = ch;
                have_prefix = 1;
            end else begin
                status = probe(prefix, ch, slot);
                if (status == 1) begin
                    prefix = slot_code[slot];
                end else begin
                    if (status == 0) begin
                        slot_used[slot]   = 1;
                        slot_code[slot]   = free_code[15:0];
                        slot_parent[slot] = prefix[15:0];
                        slot_char[slot]   = ch;
                    end
                    free_code++;
                    pack_code(prefix, width);
                    prefix = ch;
                    if (free_code > CODE_MAX) begin
                        pack_code(lzwc_pkg::CODE_FLUSH, width);
                        clear_dictionary();
                    end else if (free_code > bump_at) begin
                        pack_code(lzwc_pkg::CODE_BUMP, width);
                        width++;
                        bump_at = bump_at * 2 + 1;
                    end
                end
            end
            if (beats_now.size() > 0) beats_now[beats_now.size() - 1].last = 1'b1;
            foreach (beats_now[i]) beats_due.push_back(beats_now[i]);
        endfunction

        function bit check_beat(logic [7:0] b, logic last, output string msg);
            packed_beat_t exp_beat;
            msg = "";
            if (beats_due.size() == 0) begin
                $sformat(msg, "unexpected beat out_byte=%02h last=%0b", b, last);
                return 0;
            end
            exp_beat = beats_due.pop_front();
            if (b !== exp_beat.out_byte || last !== exp_beat.last) begin
                $sformat(msg, "beat out_byte=%02h last=%0b, predicted %02h last=%0b",
                         b, last, exp_beat.out_byte, exp_beat.last);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_mode;
    logic [7:0] s_data_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;

    lzw_scoreboard sb;
    int  mismatches;
    bit  quiet;
    int  stall_left;

    lzw_variable_width_compressor_core #(
        .MAX_CODE_BITS(CODE_BITS),
        .HASH_ENTRIES (SLOTS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last_of_run(m_last_of_run)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic report(string msg);
        $display("error at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_beat(logic mode, logic [7:0] ch);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_data_byte <= ch;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(mode, ch);
    endtask

    task automatic send_stream(int len, int alphabet);
        for (int i = 0; i < len; i++)
            send_beat(MODE_DATA, 8'($urandom_range(0, alphabet - 1)));
        send_beat(MODE_FINISH, 8'($urandom));
    endtask

    // result side: check accepted beats, stall in random bursts
    always @(posedge aclk) begin
        string msg;
        if (aresetn && m_valid && m_ready) begin
            if (!sb.check_beat(m_out_byte, m_last_of_run, msg)) report(msg);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        sb          = new();
        mismatches  = 0;
        quiet       = 0;
        stall_left  = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_mode      = MODE_DATA;
        s_data_byte = 8'h00;
        m_ready     = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty stream, single byte, extremes, repeats for matches
        send_beat(MODE_FINISH, 8'hFF);
        send_beat(MODE_DATA, 8'hFF);
        send_beat(MODE_FINISH, 8'h00);
        send_beat(MODE_DATA, 8'h00);
        send_beat(MODE_DATA, 8'hFF);
        send_beat(MODE_DATA, 8'h00);
        send_beat(MODE_DATA, 8'hFF);
        for (int i = 0; i < 10; i++) send_beat(MODE_DATA, 8'h61);
        send_beat(MODE_DATA, 8'h80);
        send_beat(MODE_DATA, 8'h7F);
        send_beat(MODE_FINISH, 8'h55);

        // random streams, some with small alphabets to build long matches
        for (int s = 0; s < 4; s++)
            send_stream($urandom_range(10, 30), (s % 2) ? 256 : $urandom_range(2, 6));
        // long stream that passes the first width step
        send_stream(290, 256);
        quiet = 1;
        send_stream(16, 4);

        @(posedge aclk);
        s_valid <= 1'b0;
        while (sb.beats_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && sb.beats_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* files.f */
hdl/lzwc_pkg.sv
hdl/lzwc_datapath.sv
hdl/lzwc_ctrl.sv
hdl/lzw_variable_width_compressor_core.sv
test/tb_lzw_variable_width_compressor_core.sv
